// File: sv/clnws_pkg.sv
package clnws_pkg;

    localparam int OP_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int STEP_W      = 4;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WCW_DEFAULT = 16;

    // request codes
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_DATA  = 3'd1;
    localparam logic [OP_W-1:0] OP_CMD   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_LINE1 = 3'd4;
    localparam logic [OP_W-1:0] OP_LINE2 = 3'd5;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd7;

    // nibble phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETUP = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd4;

    // timing register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETUP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR = 3'd6;

    localparam logic [CFG_DATA_W-1:0] RST_SETUP  = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_HIGH   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD   = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_SHORT  = 16'd37;
    localparam logic [CFG_DATA_W-1:0] RST_POWER  = 16'd20000;
    localparam logic [CFG_DATA_W-1:0] RST_CLEAR  = 16'd1520;
    localparam logic [CFG_DATA_W-1:0] RST_CURSOR = 16'd1000;

    // lcd command bytes
    localparam logic [BYTE_W-1:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [BYTE_W-1:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [BYTE_W-1:0] LCD_CLEAR      = 8'h01;
    localparam logic [BYTE_W-1:0] LCD_DISP_ON    = 8'h0F;
    localparam logic [BYTE_W-1:0] LCD_LINE1      = 8'h80;
    localparam logic [BYTE_W-1:0] LCD_LINE2      = 8'hC0;

    // sequence entry kinds
    localparam logic [1:0] K_END  = 2'd0;
    localparam logic [1:0] K_WAIT = 2'd1;
    localparam logic [1:0] K_CMD  = 2'd2;
    localparam logic [1:0] K_USER = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] arg;
    } prog_entry_t;

    function automatic prog_entry_t mk(input logic [1:0] kind, input logic [BYTE_W-1:0] arg);
        prog_entry_t e;
        e.kind = kind;
        e.arg  = arg;
        return e;
    endfunction

    function automatic logic [BYTE_W-1:0] rix(input logic [CFG_IDX_W-1:0] idx);
        return {{(BYTE_W-CFG_IDX_W){1'b0}}, idx};
    endfunction

    // fixed command programs, looked up by request code and step
    function automatic prog_entry_t prog_entry(input logic [OP_W-1:0] op,
                                               input logic [STEP_W-1:0] step);
        prog_entry_t e;
        e = mk(K_END, '0);
        unique case (op)
            OP_DATA, OP_CMD:
            begin
                if (step == 4'd0)
                    e = mk(K_USER, '0);
            end
            OP_CLEAR:
            begin
                unique case (step)
                    4'd0:    e = mk(K_WAIT, rix(REG_SHORT));
                    4'd1:    e = mk(K_CMD, LCD_CLEAR);
                    default: e = mk(K_END, '0);
                endcase
            end
            OP_LINE1, OP_LINE2:
            begin
                unique case (step)
                    4'd0:    e = mk(K_WAIT, rix(REG_SHORT));
                    4'd1:    e = mk(K_CMD, (op == OP_LINE1) ? LCD_LINE1 : LCD_LINE2);
                    4'd2:    e = mk(K_WAIT, rix(REG_CURSOR));
                    default: e = mk(K_END, '0);
                endcase
            end
            OP_INIT:
            begin
                unique case (step)
                    4'd0:    e = mk(K_WAIT, rix(REG_POWER));
                    4'd1:    e = mk(K_CMD, LCD_FUNC_SET);
                    4'd2:    e = mk(K_WAIT, rix(REG_SHORT));
                    4'd3:    e = mk(K_CMD, LCD_ENTRY_MODE);
                    4'd4:    e = mk(K_WAIT, rix(REG_SHORT));
                    4'd5:    e = mk(K_CMD, LCD_CLEAR);
                    4'd6:    e = mk(K_WAIT, rix(REG_CLEAR));
                    4'd7:    e = mk(K_CMD, LCD_DISP_ON);
                    default: e = mk(K_END, '0);
                endcase
            end
            default: e = mk(K_END, '0);
        endcase
        return e;
    endfunction

endpackage

// File: sv/clnws_if.sv
interface clnws_req_if;
    import clnws_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_value;
    modport source (output valid, operation, byte_value, input ready);
    modport sink (input valid, operation, byte_value, output ready);
endinterface

interface clnws_res_if;
    import clnws_pkg::*;
    logic             valid;
    logic             ready;
    logic [NIB_W-1:0] lcd_data;
    logic             lcd_rs;
    logic             lcd_rw;
    logic             lcd_enable;
    logic             busy_res;
    logic             rejected;
    modport source (output valid, lcd_data, lcd_rs, lcd_rw, lcd_enable, busy_res, rejected,
                    input ready);
    modport sink (input valid, lcd_data, lcd_rs, lcd_rw, lcd_enable, busy_res, rejected,
                  output ready);
endinterface

interface clnws_cfg_if;
    import clnws_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/char_lcd_nibble_write_sequencer_unit.sv
// Write-only 4-bit character LCD sequencer. Each accepted request or
// microsecond tick yields exactly one result: the bus levels (data nibble,
// rs, rw, enable), busy and a rejected flag. One item is accepted per clock
// and its result is in the output register on the next cycle; the next item
// is taken in the same cycle the held result transfers, so throughput is
// one item per cycle while res.ready is high, set by the single output register. Requests that
// arrive while a sequence runs are dropped with rejected set. Timing
// registers are written on the cfg channel, which is always ready.
module char_lcd_nibble_write_sequencer_unit
    import clnws_pkg::*;
#(
    parameter int WAIT_COUNTER_WIDTH = WCW_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    clnws_req_if.sink  req,
    clnws_res_if.source res,
    clnws_cfg_if.sink  cfg
);

    localparam int W = WAIT_COUNTER_WIDTH;

    logic [CFG_DATA_W-1:0] setup_wait_reg, high_wait_reg, hold_wait_reg, short_wait_reg;
    logic [CFG_DATA_W-1:0] power_wait_reg, clear_wait_reg, cursor_wait_reg;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               low_pend_reg, low_pend_next;
    logic [W-1:0]       cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic               rs_reg, rs_next;
    logic               en_reg, en_next;
    logic [NIB_W-1:0]   data_reg, data_next;
    logic               busy_reg, busy_next;
    logic               rej_reg, rej_next;
    logic               out_valid_reg, out_valid_next;

    logic              accept;
    logic              req_start;
    logic              do_enter;
    logic [OP_W-1:0]   e_op;
    logic [STEP_W-1:0] e_step;
    logic [BYTE_W-1:0] e_byte;
    prog_entry_t       entry;
    logic [CFG_DATA_W-1:0] wait_sel;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign res.valid      = out_valid_reg;
    assign res.lcd_data   = data_reg;
    assign res.lcd_rs     = rs_reg;
    assign res.lcd_rw     = 1'b0;
    assign res.lcd_enable = en_reg;
    assign res.busy_res   = busy_reg;
    assign res.rejected   = rej_reg;

    // a request taken while idle enters step zero of its own program
    assign req_start = accept && (req.operation != OP_TICK) && (req.operation != OP_NONE)
                       && !busy_reg;
    assign e_op      = req_start ? req.operation : op_reg;
    assign e_step    = req_start ? '0 : step_reg + 4'd1;
    assign e_byte    = req_start ? req.byte_value : held_reg;

    assign entry = prog_entry(e_op, e_step);

    always_comb
    begin
        unique case (entry.arg[CFG_IDX_W-1:0])
            REG_SETUP:  wait_sel = setup_wait_reg;
            REG_HIGH:   wait_sel = high_wait_reg;
            REG_HOLD:   wait_sel = hold_wait_reg;
            REG_SHORT:  wait_sel = short_wait_reg;
            REG_POWER:  wait_sel = power_wait_reg;
            REG_CLEAR:  wait_sel = clear_wait_reg;
            REG_CURSOR: wait_sel = cursor_wait_reg;
            default:    wait_sel = setup_wait_reg;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        low_pend_next  = low_pend_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        rs_next        = rs_reg;
        en_next        = en_reg;
        data_next      = data_reg;
        busy_next      = busy_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        do_enter       = 1'b0;

        if (res.ready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next = 1'b1;
            rej_next       = 1'b0;
            if (req.operation == OP_TICK)
            begin
                if (busy_reg && phase_reg != PH_IDLE)
                begin
                    if (cnt_reg > W'(1))
                    begin
                        cnt_next = cnt_reg - W'(1);
                    end
                    else
                    begin
                        cnt_next = '0;
                        unique case (phase_reg)
                            PH_SETUP:
                            begin
                                en_next    = 1'b1;
                                phase_next = PH_HIGH;
                                cnt_next   = W'(high_wait_reg);
                            end
                            PH_HIGH:
                            begin
                                en_next    = 1'b0;
                                phase_next = PH_HOLD;
                                cnt_next   = W'(hold_wait_reg);
                            end
                            PH_HOLD:
                            begin
                                if (low_pend_reg)
                                begin
                                    low_pend_next = 1'b0;
                                    data_next     = held_reg[NIB_W-1:0];
                                    phase_next    = PH_SETUP;
                                    cnt_next      = W'(setup_wait_reg);
                                end
                                else
                                begin
                                    do_enter = 1'b1;
                                end
                            end
                            default: do_enter = 1'b1;
                        endcase
                    end
                end
            end
            else if (req.operation != OP_NONE)
            begin
                if (busy_reg)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    op_next       = req.operation;
                    busy_next     = 1'b1;
                    low_pend_next = 1'b0;
                    held_next     = req.byte_value;
                    do_enter      = 1'b1;
                end
            end
        end

        // load the phase for the next program entry
        if (do_enter)
        begin
            step_next = e_step;
            unique case (entry.kind)
                K_WAIT:
                begin
                    phase_next = PH_WAIT;
                    cnt_next   = W'(wait_sel);
                end
                K_CMD, K_USER:
                begin
                    if (entry.kind == K_CMD)
                        held_next = entry.arg;
                    else
                        held_next = e_byte;
                    rs_next       = (e_op == OP_DATA);
                    low_pend_next = 1'b1;
                    data_next     = (entry.kind == K_CMD) ? entry.arg[BYTE_W-1:NIB_W]
                                                          : e_byte[BYTE_W-1:NIB_W];
                    phase_next    = PH_SETUP;
                    cnt_next      = W'(setup_wait_reg);
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    busy_next  = 1'b0;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_TICK;
            step_reg      <= '0;
            phase_reg     <= PH_IDLE;
            low_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            data_reg      <= '0;
            busy_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg        <= op_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            low_pend_reg  <= low_pend_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            rs_reg        <= rs_next;
            en_reg        <= en_next;
            data_reg      <= data_next;
            busy_reg      <= busy_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_wait_reg  <= RST_SETUP;
            high_wait_reg   <= RST_HIGH;
            hold_wait_reg   <= RST_HOLD;
            short_wait_reg  <= RST_SHORT;
            power_wait_reg  <= RST_POWER;
            clear_wait_reg  <= RST_CLEAR;
            cursor_wait_reg <= RST_CURSOR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SETUP:  setup_wait_reg  <= cfg.data;
                REG_HIGH:   high_wait_reg   <= cfg.data;
                REG_HOLD:   hold_wait_reg   <= cfg.data;
                REG_SHORT:  short_wait_reg  <= cfg.data;
                REG_POWER:  power_wait_reg  <= cfg.data;
                REG_CLEAR:  clear_wait_reg  <= cfg.data;
                REG_CURSOR: cursor_wait_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: sv/clnws_checker.sv
module clnws_checker
    import clnws_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [NIB_W-1:0] res_lcd_data,
    input logic             res_lcd_rw,
    input logic             res_lcd_enable,
    input logic             res_busy_res,
    input logic             res_rejected
);

    // a dropped request never ends a sequence
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rejected |-> res_busy_res)
        else $error("rejected result while not busy");

    // the strobe only rises inside a running sequence
    a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_lcd_enable |-> res_busy_res)
        else $error("enable high while idle");

    a_rw_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_lcd_rw)
        else $error("rw driven high");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_lcd_data))
        else $error("stalled result changed");

endmodule

bind char_lcd_nibble_write_sequencer_unit clnws_checker u_clnws_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_lcd_data   (res.lcd_data),
    .res_lcd_rw     (res.lcd_rw),
    .res_lcd_enable (res.lcd_enable),
    .res_busy_res   (res.busy_res),
    .res_rejected   (res.rejected)
);
